### design/ubpst_pkg.sv
package ubpst_pkg;

	// table geometry
	localparam int MAX_PATTERNS = 64;
	localparam int SLOT_W       = $clog2(MAX_PATTERNS);
	localparam int CNT_W        = $clog2(MAX_PATTERNS + 1);

	// field widths
	localparam int WORD_W     = 64;
	localparam int INDEX_W    = 6;
	localparam int POS_W      = 6;
	localparam int LEN_W      = 7;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int PCOUNT_W   = 7;

	// remainder unit: one quotient bit per cycle
	localparam int MOD_K_W  = $clog2(INDEX_W);
	localparam int MOD_SH_W = CNT_W + INDEX_W;

	localparam logic [PCOUNT_W-1:0] PCOUNT_RST = PCOUNT_W'(10);

	// operations
	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_SWAP = 2'd1;
	localparam logic [OP_W-1:0] OP_SET  = 2'd2;
	localparam logic [OP_W-1:0] OP_READ = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] ST_DONE         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_ENABLED  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_IMPROV   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_POS      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE    = 3'd4;
	localparam logic [STATUS_W-1:0] ST_LEN_MISMATCH = 3'd5;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGES_EN    = 1'd1;

	typedef struct packed {
		logic cap;       // take the input transfer
		logic mod_step;  // one restoring-remainder step
		logic rd_slot;   // read addressed entry
		logic cur_load;  // latch entry and its length
		logic dec_load;  // latch operation decision
		logic scan_rd;   // read next table entry for duplicate scan
		logic commit;    // write back and form final result
		logic out_load;  // load output register
	} dp_cmd_t;

	typedef struct packed {
		logic mod_last;
		logic need_scan;
		logic scan_last;
	} dp_sts_t;

	// top set bit position plus one
	function automatic logic [LEN_W-1:0] len_of(input logic [WORD_W-1:0] w);
		logic [LEN_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (w[i]) n = LEN_W'(i + 1);
		end
		return n;
	endfunction

endpackage

### design/ubpst_ifs.sv
interface ubpst_req_if
	import ubpst_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [INDEX_W-1:0]  index;
	logic [WORD_W-1:0]   pattern;
	logic                improvable;
	logic [POS_W-1:0]    zero_pos;
	logic [POS_W-1:0]    one_pos;

	modport source (output valid, op, index, pattern, improvable, zero_pos, one_pos,
		input ready);
	modport sink (input valid, op, index, pattern, improvable, zero_pos, one_pos,
		output ready);
endinterface

interface ubpst_rsp_if
	import ubpst_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   entry_value;
	logic                entry_improvable;
	logic [LEN_W-1:0]    entry_length;

	modport source (output valid, status, entry_value, entry_improvable, entry_length,
		input ready);
	modport sink (input valid, status, entry_value, entry_improvable, entry_length,
		output ready);
endinterface

### design/ubpst_ctrl.sv
module ubpst_ctrl
	import ubpst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MOD   = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_CUR   = 4'd3;
	localparam logic [3:0] S_DEC   = 4'd4;
	localparam logic [3:0] S_SCAN  = 4'd5;
	localparam logic [3:0] S_DRAIN = 4'd6;
	localparam logic [3:0] S_WR    = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_d = S_RD;
			end
			S_RD: begin
				cmd.rd_slot = 1'b1;
				state_d     = S_CUR;
			end
			S_CUR: begin
				cmd.cur_load = 1'b1;
				state_d      = S_DEC;
			end
			S_DEC: begin
				cmd.dec_load = 1'b1;
				state_d      = sts.need_scan ? S_SCAN : S_WR;
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_WR;
			S_WR: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				// output register must be free or emptied this cycle
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

### design/ubpst_dp.sv
module ubpst_dp
	import ubpst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_sts_t               sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [OP_W-1:0]       in_op,
	input  logic [INDEX_W-1:0]    in_index,
	input  logic [WORD_W-1:0]     in_pattern,
	input  logic                  in_improvable,
	input  logic [POS_W-1:0]      in_zero_pos,
	input  logic [POS_W-1:0]      in_one_pos,
	output logic [STATUS_W-1:0]   out_status,
	output logic [WORD_W-1:0]     out_value,
	output logic                  out_improvable,
	output logic [LEN_W-1:0]      out_length
);

	// config
	logic [PCOUNT_W-1:0] pcount_q;
	logic                chg_en_q;
	logic [CNT_W-1:0]    cnt;

	// captured item
	logic [OP_W-1:0]    op_q;
	logic [INDEX_W-1:0] rem_q;
	logic [MOD_K_W-1:0] k_q;
	logic [WORD_W-1:0]  pat_q;
	logic               pflag_q;
	logic [LEN_W-1:0]   pat_len_q;
	logic [POS_W-1:0]   zpos_q;
	logic [POS_W-1:0]   opos_q;

	// table and entry under work
	logic [WORD_W:0]    mem_q [MAX_PATTERNS];
	logic [WORD_W:0]    rd_q;
	logic [WORD_W-1:0]  cur_q;
	logic               cur_flag_q;
	logic [LEN_W-1:0]   cur_len_q;

	// decision
	logic [STATUS_W-1:0] status_q, dec_status;
	logic [WORD_W-1:0]   new_val_q, dec_val, cand;
	logic                new_flag_q, dec_flag;
	logic                wr_q, dec_wr, need_scan, pos_bad;

	// duplicate scan
	logic [SLOT_W-1:0]   scan_q;
	logic                cmp_en_q;
	logic                dup_q;

	// final result
	logic [STATUS_W-1:0] fin_status_q;
	logic [WORD_W-1:0]   fin_val_q;
	logic                fin_flag_q;
	logic                commit_wr;

	// output register
	logic [STATUS_W-1:0] out_status_q;
	logic [WORD_W-1:0]   out_val_q;
	logic                out_flag_q;
	logic [LEN_W-1:0]    out_len_q;

	logic [MOD_SH_W-1:0] dvs, rem_ext;
	logic [SLOT_W-1:0]   slot, raddr;

	// count clamped to 1..MAX_PATTERNS
	always_comb begin
		if (pcount_q == '0) cnt = CNT_W'(1);
		else if (int'(pcount_q) > MAX_PATTERNS) cnt = CNT_W'(MAX_PATTERNS);
		else cnt = CNT_W'(pcount_q);
	end

	assign dvs     = MOD_SH_W'(cnt) << k_q;
	assign rem_ext = MOD_SH_W'(rem_q);
	assign slot    = SLOT_W'(rem_q);
	assign raddr   = cmd.scan_rd ? scan_q : slot;

	assign cand    = (cur_q & ~(WORD_W'(1) << opos_q)) | (WORD_W'(1) << zpos_q);
	assign pos_bad = (LEN_W'(zpos_q) >= cur_len_q) || (LEN_W'(opos_q) >= cur_len_q)
		|| !cur_q[opos_q] || cur_q[zpos_q];

	always_comb begin
		dec_status = ST_DONE;
		dec_val    = cur_q;
		dec_flag   = cur_flag_q;
		dec_wr     = 1'b0;
		need_scan  = 1'b0;
		unique case (op_q)
			OP_LOAD: begin
				dec_val  = pat_q;
				dec_flag = pflag_q;
				dec_wr   = 1'b1;
			end
			OP_SWAP: begin
				if (!chg_en_q) dec_status = ST_NOT_ENABLED;
				else if (!cur_flag_q) dec_status = ST_NOT_IMPROV;
				else if (pos_bad) dec_status = ST_BAD_POS;
				else begin
					dec_val   = cand;
					dec_wr    = 1'b1;
					need_scan = 1'b1;
				end
			end
			OP_SET: begin
				if (pat_len_q == cur_len_q) begin
					dec_val = pat_q;
					dec_wr  = 1'b1;
				end else begin
					dec_status = ST_LEN_MISMATCH;
				end
			end
			OP_READ: ;
			default: ;
		endcase
	end

	assign commit_wr = wr_q && !dup_q;

	assign sts.mod_last  = (k_q == '0);
	assign sts.need_scan = need_scan;
	assign sts.scan_last = (CNT_W'(scan_q) == cnt - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcount_q <= PCOUNT_RST;
			chg_en_q <= 1'b0;
			cmp_en_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PATTERN_COUNT: pcount_q <= cfg_data;
					CFG_CHANGES_EN:    chg_en_q <= cfg_data[0];
					default: ;
				endcase
			end
			cmp_en_q <= cmd.scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q      <= in_op;
			rem_q     <= in_index;
			k_q       <= MOD_K_W'(INDEX_W - 1);
			pat_q     <= in_pattern;
			pflag_q   <= in_improvable;
			pat_len_q <= len_of(in_pattern);
			zpos_q    <= in_zero_pos;
			opos_q    <= in_one_pos;
			dup_q     <= 1'b0;
		end
		if (cmd.mod_step) begin
			if (rem_ext >= dvs) rem_q <= INDEX_W'(rem_ext - dvs);
			k_q <= k_q - MOD_K_W'(1);
		end
		if (cmd.cur_load) begin
			cur_q      <= rd_q[WORD_W-1:0];
			cur_flag_q <= rd_q[WORD_W];
			cur_len_q  <= len_of(rd_q[WORD_W-1:0]);
		end
		if (cmd.dec_load) begin
			status_q   <= dec_status;
			new_val_q  <= dec_val;
			new_flag_q <= dec_flag;
			wr_q       <= dec_wr;
			scan_q     <= '0;
		end
		if (cmd.scan_rd) scan_q <= scan_q + SLOT_W'(1);
		if (cmp_en_q && (rd_q[WORD_W-1:0] == new_val_q)) dup_q <= 1'b1;
		if (cmd.commit) begin
			fin_status_q <= dup_q ? ST_DUPLICATE : status_q;
			fin_val_q    <= commit_wr ? new_val_q : cur_q;
			fin_flag_q   <= commit_wr ? new_flag_q : cur_flag_q;
		end
		if (cmd.out_load) begin
			out_status_q <= fin_status_q;
			out_val_q    <= fin_val_q;
			out_flag_q   <= chg_en_q & fin_flag_q;
			out_len_q    <= len_of(fin_val_q);
		end
	end

	// pattern table, flag in the top bit
	always_ff @(posedge clk) begin
		if (cmd.commit && commit_wr) mem_q[slot] <= {new_flag_q, new_val_q};
		if (cmd.rd_slot || cmd.scan_rd) rd_q <= mem_q[raddr];
	end

	assign out_status     = out_status_q;
	assign out_value      = out_val_q;
	assign out_improvable = out_flag_q;
	assign out_length     = out_len_q;

endmodule

### design/unique_bit_pattern_swap_table_unit.sv
// Spaced-seed pattern table with guarded bit swaps.
// Channels: req (sink) carries op, index, pattern, improvable, zero_pos, one_pos;
// rsp (source) returns status, entry_value, entry_improvable, entry_length.
// A transfer happens on a clock edge with valid and ready both high. Every
// request yields exactly one response describing the addressed entry after
// the operation. cfg_we/cfg_index/cfg_data write pattern_count (index 0) and
// changes_enabled (index 1); write only while no request is in flight.
// Sequence: the index remainder, one step per quotient bit, then read, entry
// latch, decode, write-back and output load. A swap that passes its checks
// adds a uniqueness scan over every entry in use (pattern_count clamped to
// 1..64), one table read per cycle through the single read port, and a drain
// step. A new request is taken in the cycle after the previous response is
// loaded, so the block works on one request at a time.
// A stalled response sits in the output register; the next request is still
// taken and runs until its own response would overwrite, then waits.
// Reset (arst_n low, async) returns the controller to idle, drops rsp.valid
// and restores pattern_count to 10 and changes_enabled to 0. Table contents
// are not cleared; entries must be loaded before they are read or scanned.
module unique_bit_pattern_swap_table_unit
	import ubpst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ubpst_req_if.sink             req,
	ubpst_rsp_if.source           rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: one item at a time, output register decoupled
	ubpst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// remainder unit, table memory, checks, scan compare and output register
	ubpst_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_op          (req.op),
		.in_index       (req.index),
		.in_pattern     (req.pattern),
		.in_improvable  (req.improvable),
		.in_zero_pos    (req.zero_pos),
		.in_one_pos     (req.one_pos),
		.out_status     (rsp.status),
		.out_value      (rsp.entry_value),
		.out_improvable (rsp.entry_improvable),
		.out_length     (rsp.entry_length)
	);

endmodule

### design/ubpst_chk.sv
module ubpst_chk
	import ubpst_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [WORD_W-1:0]   rsp_value,
	input logic [LEN_W-1:0]    rsp_length
);

	// busy right after taking a request
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready high right after a request transfer");

	// a response never appears the cycle after a request transfer
	a_no_instant_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_valid && req_ready))
		else $error("response too early");

	// status stays within its code set
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status <= ST_LEN_MISMATCH)
		else $error("status code out of range");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_value) && $stable(rsp_length))
		else $error("stalled response changed");

endmodule

bind unique_bit_pattern_swap_table_unit ubpst_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_value  (rsp.entry_value),
	.rsp_length (rsp.entry_length)
);

### tb/sv/tb_unique_bit_pattern_swap_table_unit.sv
module tb_unique_bit_pattern_swap_table_unit;
	import ubpst_pkg::*;

	// No transfer on either channel for this many cycles ends the run. The slowest
	// legal stretch is the long receiver hold-off plus a scanning swap plus a
	// sender gap, so this leaves a wide margin.
	localparam int QUIET_LIMIT     = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int PHASE_ITEMS     = 100;

	// One request as it crosses the req channel.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [INDEX_W-1:0] index;
		logic [WORD_W-1:0]  pattern;
		logic               improvable;
		logic [POS_W-1:0]   zero_pos;
		logic [POS_W-1:0]   one_pos;
	} table_req_t;

	// One response: the addressed entry after the operation.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [WORD_W-1:0]   entry_value;
		logic                entry_improvable;
		logic [LEN_W-1:0]    entry_length;
	} entry_report_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ubpst_req_if req_ch ();
	ubpst_rsp_if rsp_ch ();

	unique_bit_pattern_swap_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the table and its registers, advanced once per accepted request.
	logic [WORD_W-1:0]   tbl_word [MAX_PATTERNS];
	logic                tbl_flag [MAX_PATTERNS];
	logic [PCOUNT_W-1:0] cfg_count   = PCOUNT_RST;
	logic                cfg_changes = 1'b0;

	entry_report_t outcome_q [$];   // reports owed by the block, oldest first
	int mismatch_count = 0;
	int burst_left     = 0;         // requests left in the current sender burst
	int hold_off_requests = 0;      // bumped by a test to make the receiver hold off

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Top set bit position plus one; zero for an empty word.
	function automatic logic [LEN_W-1:0] top_bit_count(input logic [WORD_W-1:0] w);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) return LEN_W'(i + 1);
		end
		return '0;
	endfunction

	// Entries in use: a count of zero acts as one, anything past the table as the table.
	function automatic int unsigned used_count();
		if (cfg_count == 0) return 1;
		if (cfg_count > MAX_PATTERNS) return MAX_PATTERNS;
		return cfg_count;
	endfunction

	// Applies one request to the shadow table and returns the report it must produce.
	function automatic entry_report_t table_op_outcome(input table_req_t r);
		int unsigned       n_used;
		int unsigned       slot;
		logic [WORD_W-1:0] cur;
		logic [WORD_W-1:0] cand;
		logic [LEN_W-1:0]  cur_len;
		logic              dup;
		entry_report_t     o;
		n_used = used_count();
		slot = r.index % n_used;
		o = '0;
		o.status = ST_DONE;
		case (r.op)
		OP_LOAD: begin
			tbl_word[slot] = r.pattern;
			tbl_flag[slot] = r.improvable;
		end
		OP_SWAP: begin
			cur = tbl_word[slot];
			cur_len = top_bit_count(cur);
			cand = cur;
			cand[r.one_pos] = 1'b0;
			cand[r.zero_pos] = 1'b1;
			if (!cfg_changes) begin
				o.status = ST_NOT_ENABLED;
			end else if (!tbl_flag[slot]) begin
				o.status = ST_NOT_IMPROV;
			end else if (r.zero_pos >= cur_len || r.one_pos >= cur_len ||
					!cur[r.one_pos] || cur[r.zero_pos]) begin
				o.status = ST_BAD_POS;
			end else begin
				// commit only if the moved word appears nowhere in the entries in use
				dup = 1'b0;
				for (int i = 0; i < n_used; i++) begin
					if (tbl_word[i] == cand) dup = 1'b1;
				end
				if (dup) o.status = ST_DUPLICATE;
				else tbl_word[slot] = cand;
			end
		end
		OP_SET: begin
			// set is not gated; the length has to stay the same, the flag is untouched
			if (top_bit_count(r.pattern) == top_bit_count(tbl_word[slot]))
				tbl_word[slot] = r.pattern;
			else
				o.status = ST_LEN_MISMATCH;
		end
		default: ;
		endcase
		o.entry_value = tbl_word[slot];
		o.entry_improvable = cfg_changes ? tbl_flag[slot] : 1'b0;
		o.entry_length = top_bit_count(tbl_word[slot]);
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic table_req_t make_req(input logic [OP_W-1:0] op,
			input logic [INDEX_W-1:0] index, input logic [WORD_W-1:0] pattern,
			input logic improvable, input logic [POS_W-1:0] zero_pos,
			input logic [POS_W-1:0] one_pos);
		table_req_t r;
		r.op = op;
		r.index = index;
		r.pattern = pattern;
		r.improvable = improvable;
		r.zero_pos = zero_pos;
		r.one_pos = one_pos;
		return r;
	endfunction

	// Mostly short words so that duplicates turn up; some full-width ones so every
	// pattern bit toggles.
	function automatic logic [WORD_W-1:0] random_word();
		int unsigned       pick;
		int unsigned       width;
		logic [WORD_W-1:0] w;
		pick = $urandom_range(0, 9);
		if (pick < 3) width = WORD_W;
		else if (pick < 8) width = $urandom_range(1, 8);
		else width = $urandom_range(0, WORD_W);
		w = {$urandom, $urandom};
		if (width < WORD_W) w = w & ((64'd1 << width) - 64'd1);
		return w;
	endfunction

	function automatic table_req_t random_table_req();
		table_req_t        r;
		int unsigned       pick;
		int unsigned       slot;
		int                n1;
		int                n0;
		int                k1;
		int                k0;
		logic [WORD_W-1:0] cur;
		logic [LEN_W-1:0]  cur_len;
		pick = $urandom_range(0, 99);
		r = make_req(OP_READ, INDEX_W'($urandom), random_word(),
			$urandom_range(0, 4) != 0, POS_W'($urandom), POS_W'($urandom));
		if (pick < 20) r.op = OP_LOAD;
		else if (pick < 65) r.op = OP_SWAP;
		else if (pick < 80) r.op = OP_SET;
		slot = r.index % used_count();
		cur = tbl_word[slot];
		cur_len = top_bit_count(cur);
		if (r.op == OP_SWAP && $urandom_range(0, 4) != 0) begin
			// well-formed move: a set bit and a clear bit, both below the length
			n1 = 0;
			n0 = 0;
			for (int i = 0; i < cur_len; i++) begin
				if (cur[i]) n1++;
				else n0++;
			end
			if (n1 != 0 && n0 != 0) begin
				k1 = $urandom_range(0, n1 - 1);
				k0 = $urandom_range(0, n0 - 1);
				for (int i = 0; i < cur_len; i++) begin
					if (cur[i]) begin
						if (k1 == 0) r.one_pos = POS_W'(i);
						k1--;
					end else begin
						if (k0 == 0) r.zero_pos = POS_W'(i);
						k0--;
					end
				end
			end
		end
		if (r.op == OP_SET && $urandom_range(0, 3) != 0) begin
			// same top bit as the stored word, random below it
			r.pattern = {$urandom, $urandom};
			if (cur_len == 0) begin
				r.pattern = '0;
			end else begin
				r.pattern = r.pattern & ((64'd1 << (cur_len - 1)) - 64'd1);
				r.pattern[cur_len - 1] = 1'b1;
			end
		end
		return r;
	endfunction

	// Offers one request and waits for its transfer. Valid stays high afterwards so
	// that back-to-back requests need no second assignment in the same step; whoever
	// stops sending lowers it.
	task automatic send_table_req(input table_req_t r);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid      <= 1'b1;
		req_ch.op         <= r.op;
		req_ch.index      <= r.index;
		req_ch.pattern    <= r.pattern;
		req_ch.improvable <= r.improvable;
		req_ch.zero_pos   <= r.zero_pos;
		req_ch.one_pos    <= r.one_pos;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		outcome_q.insert(outcome_q.size(), table_op_outcome(r));
	endtask

	// Stop offering and wait until every owed report is in, then a short pause.
	task automatic settle_idle();
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges; only called while idle.
	task automatic write_config(input logic [CFG_DATA_W-1:0] count,
			input logic [CFG_DATA_W-1:0] changes);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PATTERN_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		cfg_count = count;
		cfg_index <= CFG_CHANGES_EN;
		cfg_data  <= changes;
		@(posedge clk);
		cfg_changes = changes[0];
		cfg_we <= 1'b0;
	endtask

	// Loads every entry in use, so later reads and uniqueness scans only see
	// written entries. The index is an arbitrary alias of the slot.
	task automatic preload_table();
		int unsigned n_used;
		table_req_t  r;
		n_used = used_count();
		for (int i = 0; i < n_used; i++) begin
			r = make_req(OP_LOAD, INDEX_W'(i + n_used * $urandom_range(0, (63 - i) / n_used)),
				random_word(), $urandom_range(0, 4) != 0, POS_W'($urandom), POS_W'($urandom));
			send_table_req(r);
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		// keep the log bounded if the block is badly broken
		if (mismatch_count <= 100) $display("mismatch at %0t: %s", $time, what);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: ten entries in use, changes off. Swaps are refused, flags read 0,
	// set still works, and indexes wrap modulo ten.
	task automatic test_reset_defaults();
		for (int i = 0; i < 10; i++) begin
			case (i)
			0: send_table_req(make_req(OP_LOAD, 6'd0, '0, 1'b1, '0, '0));
			1: send_table_req(make_req(OP_LOAD, 6'd1, '1, 1'b0, '0, '0));
			2: send_table_req(make_req(OP_LOAD, 6'd2, 64'h8000_0000_0000_0000, 1'b1, '0, '0));
			3: send_table_req(make_req(OP_LOAD, 6'd63, 64'h35, 1'b1, '0, '0));
			default: send_table_req(make_req(OP_LOAD, INDEX_W'(i), (64'(i) << 4) | 64'h5,
				1'b1, '0, '0));
			endcase
		end
		send_table_req(make_req(OP_SWAP, 6'd3, '0, 1'b0, 6'd1, 6'd0));
		send_table_req(make_req(OP_SET, 6'd10, '0, 1'b0, '0, '0));
		send_table_req(make_req(OP_READ, 6'd61, '0, 1'b0, '0, '0));
	endtask

	// Every swap outcome with changes enabled and both set outcomes on a four-entry table.
	task automatic test_directed_swaps();
		settle_idle();
		write_config(7'd4, 7'd1);
		send_table_req(make_req(OP_LOAD, 6'd0, 64'hB, 1'b1, '0, '0));
		send_table_req(make_req(OP_LOAD, 6'd1, 64'hD, 1'b1, '0, '0));
		send_table_req(make_req(OP_LOAD, 6'd2, 64'h0, 1'b1, '0, '0));
		send_table_req(make_req(OP_LOAD, 6'd3, 64'h8000_0000_0000_0001, 1'b0, '0, '0));
		// flag clear
		send_table_req(make_req(OP_SWAP, 6'd3, '0, 1'b0, 6'd62, 6'd63));
		// empty entry has no valid position
		send_table_req(make_req(OP_SWAP, 6'd2, '0, 1'b0, 6'd0, 6'd0));
		// 1011 -> 1101 already stored in entry 1
		send_table_req(make_req(OP_SWAP, 6'd0, '0, 1'b0, 6'd2, 6'd1));
		// source bit clear
		send_table_req(make_req(OP_SWAP, 6'd0, '0, 1'b0, 6'd2, 6'd2));
		// target beyond the length
		send_table_req(make_req(OP_SWAP, 6'd0, '0, 1'b0, 6'd5, 6'd0));
		// top bit moves down: 1011 -> 0111, length shrinks
		send_table_req(make_req(OP_SWAP, 6'd4, '0, 1'b0, 6'd2, 6'd3));
		send_table_req(make_req(OP_SET, 6'd1, 64'h9, 1'b0, '0, '0));
		send_table_req(make_req(OP_SET, 6'd5, 64'h10, 1'b0, '0, '0));
		// extreme positions on a full-length word
		send_table_req(make_req(OP_LOAD, 6'd7, 64'h8000_0000_0000_0001, 1'b1, '0, '0));
		send_table_req(make_req(OP_SWAP, 6'd63, '0, 1'b0, 6'd62, 6'd63));
	endtask

	// Receiver holds off for a long stretch while requests keep coming, so the block
	// backs up and stalls its input.
	task automatic test_backpressure();
		hold_off_requests++;
		repeat (10) send_table_req(random_table_req());
	endtask

	// Several register settings, the extremes among them, each with a fresh preload
	// and a batch of mostly well-formed random requests.
	task automatic test_random_phases();
		logic [CFG_DATA_W-1:0] counts  [8];
		logic [CFG_DATA_W-1:0] changes [8];
		counts  = '{7'd1, 7'd2, 7'd127, 7'd0, 7'd65, CFG_DATA_W'($urandom_range(3, 63)),
			7'd10, CFG_DATA_W'($urandom_range(2, 8))};
		// upper data bits must not matter for the enable
		changes = '{7'h01, 7'h7F, 7'h01, 7'h7F, 7'h7E, 7'h01, 7'h00, 7'h03};
		for (int p = 0; p < 8; p++) begin
			settle_idle();
			write_config(counts[p], changes[p]);
			preload_table();
			repeat (PHASE_ITEMS) send_table_req(random_table_req());
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver: ready pattern of its own, switching to a new random mode whenever the current one runs out,
	// plus the long hold-off on request.
	// ------------------------------------------------------------------
	initial begin : rsp_ready_pattern
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		int          holds_served;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		holds_served = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_requests != holds_served) begin
				holds_served = hold_off_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(40, 300);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
				0: rsp_ch.ready <= 1'b1;                          // no stalls
				1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
				2: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
				default: rsp_ch.ready <= (mode_left % 3 == 0);    // periodic
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Report check: every rsp transfer against the oldest owed report
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_entry_reports
		entry_report_t want;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("response transfer with no request outstanding");
			end else begin
				want = outcome_q.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.entry_value !== want.entry_value)
					report_mismatch($sformatf("entry_value %h, expected %h",
						rsp_ch.entry_value, want.entry_value));
				if (rsp_ch.entry_improvable !== want.entry_improvable)
					report_mismatch($sformatf("entry_improvable %b, expected %b",
						rsp_ch.entry_improvable, want.entry_improvable));
				if (rsp_ch.entry_length !== want.entry_length)
					report_mismatch($sformatf("entry_length %0d, expected %0d",
						rsp_ch.entry_length, want.entry_length));
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: cycles with no transfer on either channel
	// ------------------------------------------------------------------
	always @(posedge clk) begin : quiet_watchdog
		int quiet_cycles;
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_PATTERN_COUNT;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_READ;
		req_ch.index      = '0;
		req_ch.pattern    = '0;
		req_ch.improvable = 1'b0;
		req_ch.zero_pos   = '0;
		req_ch.one_pos    = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_swaps();
		test_backpressure();
		test_random_phases();

		// drain, then give any stray response time to show up
		settle_idle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
